// ===== hw/rtl/sfla_pkg.sv =====
// Package for the segregated free-list allocator: widths, opcodes, FSM states.
// No dependencies.
package sfla_pkg;
    localparam int ArenaBytes   = 65536;
    localparam int HeaderBytes  = 16;
    localparam int MinPageBytes = 8192;
    localparam int GranuleBytes = 32;
    localparam int SizeClasses  = 10;
    localparam int BlockSlots   = 2048;
    localparam int LargeClass   = SizeClasses - 1;
    localparam int SlotW  = $clog2(BlockSlots);
    localparam int LinkW  = SlotW + 1;
    localparam int SizeW  = 17;
    localparam int ClassW = $clog2(SizeClasses);
    localparam int GranW  = $clog2(GranuleBytes);
    localparam int StepW  = SlotW + 1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RSIZE,   // read old block size (free / realloc)
        S_CHECK,   // realloc fit test / free class select
        S_AHEAD,   // alloc: evaluate class head
        S_WREAD,   // class list: read size+link of cur
        S_WTEST,   // class list: compare size (large class only)
        S_POP,     // unlink found block
        S_UNLINK,  // clear popped block's link after a splice
        S_BUMP,    // bump / new page
        S_FREE,    // push old block (realloc move)
        S_OUT      // result beat waiting
    } t_state;

    // class of a rounded size: smallest k with n <= Granule<<k, else large
    function automatic logic [ClassW-1:0] class_of(input logic [SizeW:0] n);
        logic [ClassW-1:0] k;
        k = ClassW'(LargeClass);
        for (int i = LargeClass - 1; i >= 0; i--)
            if (n <= ((SizeW+1)'(GranuleBytes) << i)) k = ClassW'(i);
        return k;
    endfunction
endpackage

// ===== hw/rtl/segregated_free_list_allocator.sv =====
// Segregated free-list allocator, top level (single module).
// Depends on sfla_pkg.
//
// channel | direction | signals
// request | in        | i_valid/o_ready, i_operation, i_request_bytes, i_address
// result  | out       | o_valid/i_ready, o_result_address, o_status, o_copy_needed
//
// One item at a time. Null free and release go straight to the result; free and
// realloc first read the old size; alloc checks the class head, then bumps or pops,
// plus an unlink step for a large-class hit spliced out behind another entry.
// Large-class first-fit walks read and compare each further entry, up to 2048.
// A moving realloc finds the new block, then rereads the old size and pushes it.
// Block memories have no clearing pass; class heads and page registers reset at
// once. Result waits in an output register; a stall on it holds the next request off.
module segregated_free_list_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_request_bytes,
    input  logic [15:0] i_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result_address,
    output logic        o_status,
    output logic        o_copy_needed
);
    import sfla_pkg::*;

    // block memories: link and size, one read port each, registered data
    logic [LinkW-1:0] link_mem [BlockSlots];
    logic [SizeW-1:0] size_mem [BlockSlots];
    logic [LinkW-1:0] r_link_q;
    logic [SizeW-1:0] r_size_q;
    logic [SlotW-1:0] rd_addr;
    logic             lw_en, sw_en;
    logic [SlotW-1:0] lw_addr, sw_addr;
    logic [LinkW-1:0] lw_data;
    logic [SizeW-1:0] sw_data;

    always_ff @(posedge i_clk) begin
        if (lw_en) link_mem[lw_addr] <= lw_data;
        if (sw_en) size_mem[sw_addr] <= sw_data;
        r_link_q <= link_mem[rd_addr];
        r_size_q <= size_mem[rd_addr];
    end

    t_state r_state, n_state;
    logic [LinkW-1:0] r_head [SizeClasses];
    logic [SizeW-1:0] r_cursor, r_limit;
    t_op              r_op;
    logic [15:0]      r_addr;
    logic [15:0]      r_req;      // raw payload request, for the realloc fit test
    logic [SizeW:0]   r_n;        // rounded request size
    logic [ClassW-1:0] r_k;
    logic [LinkW-1:0] r_cur, r_prev;
    logic [StepW-1:0] r_steps;
    logic [15:0]      r_res;
    logic             r_stat, r_copy, r_move;

    // request sizing
    logic [SizeW:0]    req_hdr, req_rnd;
    logic [ClassW-1:0] req_k;
    assign req_hdr = (SizeW+1)'(i_request_bytes) + (SizeW+1)'(HeaderBytes);
    always_comb begin
        req_rnd = (req_hdr + (SizeW+1)'(GranuleBytes - 1)) & ~(SizeW+1)'(GranuleBytes - 1);
        req_k   = class_of(req_rnd);
        if (req_k != ClassW'(LargeClass))
            req_rnd = (SizeW+1)'(GranuleBytes) << req_k;
    end

    logic [15:0]      old_start;
    logic [SlotW-1:0] old_slot;
    assign old_start = r_addr - 16'(HeaderBytes);
    assign old_slot  = SlotW'(old_start >> GranW);

    // realloc of a live block: old block must be pushed after the new one is found
    logic is_move;
    assign is_move = (r_op == OP_REALLOC) && (r_addr != '0);

    // bump / page arithmetic
    logic [SizeW:0] room, page_sz, new_lim;
    logic           bump_ok, page_ok;
    logic [SizeW-1:0] start;
    always_comb begin
        room    = (SizeW+1)'(r_limit) - (SizeW+1)'(r_cursor);
        bump_ok = (r_limit != '0) && (r_cursor <= r_limit) && (room >= r_n);
        page_sz = (r_n > (SizeW+1)'(MinPageBytes)) ? r_n : (SizeW+1)'(MinPageBytes);
        new_lim = (SizeW+1)'(r_limit) + page_sz;
        page_ok = ((SizeW+1)'(r_limit) <= (SizeW+1)'(ArenaBytes))
                  && (new_lim <= (SizeW+1)'(ArenaBytes));
        start   = bump_ok ? r_cursor : r_limit;
    end

    logic [ClassW-1:0] free_k;
    assign free_k = class_of({1'b0, r_size_q});
    logic [SlotW-1:0] cur_slot, prev_slot;
    assign cur_slot  = SlotW'(r_cur - LinkW'(1));
    assign prev_slot = SlotW'(r_prev - LinkW'(1));

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_result_address = r_res;
    assign o_status = r_stat;
    assign o_copy_needed = r_copy;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                unique case (t_op'(i_operation))
                    OP_ALLOC:   n_state = S_AHEAD;
                    OP_FREE:    n_state = (i_address == '0) ? S_OUT : S_RSIZE;
                    OP_REALLOC: n_state = (i_address == '0) ? S_AHEAD : S_RSIZE;
                    OP_RELEASE: n_state = S_OUT;
                endcase
            end
            S_RSIZE: n_state = S_CHECK;
            S_CHECK: begin
                if (r_move) n_state = S_FREE;
                else if (r_op == OP_FREE) n_state = S_OUT;
                else if ({1'b0, r_size_q} >= (SizeW+1)'(r_req) + (SizeW+1)'(HeaderBytes))
                    n_state = S_OUT;
                else n_state = S_AHEAD;
            end
            S_AHEAD: begin
                if (r_head[r_k] == '0) n_state = S_BUMP;
                else if (r_k == ClassW'(LargeClass)) n_state = S_WREAD;
                else n_state = S_WREAD;
            end
            S_WREAD: n_state = S_WTEST;
            S_WTEST: begin
                if (r_k != ClassW'(LargeClass) || {1'b0, r_size_q} >= r_n)
                    n_state = S_POP;
                else if (r_link_q == '0 || r_steps + StepW'(1) >= StepW'(BlockSlots))
                    n_state = S_BUMP;
                else n_state = S_WREAD;
            end
            S_POP: begin
                if (r_prev != '0) n_state = S_UNLINK;
                else n_state = is_move ? S_RSIZE : S_OUT;
            end
            S_UNLINK: n_state = is_move ? S_RSIZE : S_OUT;
            S_BUMP: n_state = ((bump_ok || page_ok) && is_move) ? S_RSIZE : S_OUT;
            S_FREE: n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        rd_addr = old_slot;
        lw_en = 1'b0; sw_en = 1'b0;
        lw_addr = cur_slot; sw_addr = SlotW'(start >> GranW);
        lw_data = '0; sw_data = SizeW'(r_n);
        unique case (r_state)
            S_IDLE:  rd_addr = SlotW'((i_address - 16'(HeaderBytes)) >> GranW);
            S_RSIZE: rd_addr = old_slot;
            S_WREAD: rd_addr = cur_slot;
            S_WTEST: rd_addr = cur_slot;   // keep cur's link in the read register
            S_CHECK: if (r_op == OP_FREE && !r_move) begin
                lw_en = 1'b1; lw_addr = old_slot; lw_data = r_head[free_k];
            end
            S_POP: begin
                lw_en = 1'b1;
                if (r_prev != '0) begin
                    // splice: prev.link <= cur.link, cur.link cleared next cycle
                    lw_addr = prev_slot; lw_data = r_link_q;
                end else begin
                    lw_addr = cur_slot; lw_data = '0;
                end
            end
            S_UNLINK: begin
                lw_en = 1'b1; lw_addr = cur_slot; lw_data = '0;
            end
            S_FREE: begin
                lw_en = 1'b1; lw_addr = old_slot; lw_data = r_head[free_k];
            end
            S_BUMP: if (bump_ok || page_ok) begin
                lw_en = 1'b1; lw_addr = SlotW'(start >> GranW); lw_data = '0;
                sw_en = 1'b1;
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= '0;
            r_limit  <= '0;
            r_move   <= 1'b0;
            for (int i = 0; i < SizeClasses; i++) r_head[i] <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op   <= t_op'(i_operation);
                    r_addr <= i_address;
                    r_req  <= i_request_bytes;
                    r_n    <= req_rnd;
                    r_k    <= req_k;
                    r_res  <= '0;
                    r_stat <= 1'b0;
                    r_copy <= 1'b0;
                    r_move <= 1'b0;
                    r_prev <= '0;
                    r_steps <= '0;
                    if (t_op'(i_operation) == OP_RELEASE) begin
                        r_cursor <= '0;
                        r_limit  <= '0;
                        for (int i = 0; i < SizeClasses; i++) r_head[i] <= '0;
                    end
                end
                S_RSIZE: ;
                S_CHECK: begin
                    if (r_move) begin
                        // second pass of a moving realloc: old size now read
                    end else if (r_op == OP_FREE) begin
                        r_head[free_k] <= LinkW'(old_slot) + LinkW'(1);
                    end else if (n_state == S_OUT) begin
                        r_res <= r_addr;
                    end
                end
                S_AHEAD: r_cur <= r_head[r_k];
                S_WREAD: ;
                S_WTEST: if (n_state == S_WREAD) begin
                    r_prev  <= r_cur;
                    r_cur   <= r_link_q;
                    r_steps <= r_steps + StepW'(1);
                end
                S_POP: begin
                    if (r_prev == '0) r_head[r_k] <= r_link_q;
                    r_res <= 16'({cur_slot, GranW'(0)}) + 16'(HeaderBytes);
                    if (is_move) begin
                        r_move <= 1'b1; r_copy <= 1'b1;
                    end
                end
                S_UNLINK: ;
                S_BUMP: begin
                    if (bump_ok) begin
                        r_cursor <= SizeW'((SizeW+1)'(r_cursor) + r_n);
                    end else if (page_ok) begin
                        r_cursor <= SizeW'((SizeW+1)'(r_limit) + r_n);
                        r_limit  <= SizeW'(new_lim);
                    end
                    if (bump_ok || page_ok) begin
                        r_res <= start[15:0] + 16'(HeaderBytes);
                        if (is_move) begin
                            r_move <= 1'b1; r_copy <= 1'b1;
                        end
                    end else begin
                        r_stat <= 1'b1;
                    end
                end
                S_FREE: begin
                    r_head[free_k] <= LinkW'(old_slot) + LinkW'(1);
                    r_move <= 1'b0;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the segregated free-list allocator.
// Needs sfla_pkg and segregated_free_list_allocator; nothing else.
module tb_top;
    import sfla_pkg::*;

    typedef struct packed {
        t_op         op;
        logic [15:0] req;
        logic [15:0] addr;
    } t_request;

    typedef struct packed {
        logic [15:0] addr;
        logic        status;
        logic        copy;
    } t_response;

    localparam int unsigned CycleLimit = 20_000_000;
    localparam int unsigned RandomBeats = 1100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [15:0] i_request_bytes;
    logic [15:0] i_address;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_result_address;
    logic        o_status;
    logic        o_copy_needed;

    segregated_free_list_allocator dut (.*);

    // Predictor state: own copy of list heads, block stores and page registers.
    logic [11:0] heads [SizeClasses];
    logic [11:0] links [BlockSlots];
    logic [16:0] sizes [BlockSlots];
    bit          stored [BlockSlots];   // slot has been given a size at least once
    int unsigned cursor, limit;

    t_request    pending_beats[$];
    t_response   expected_results[$];
    int unsigned live_blocks[$];        // payload addresses currently handed out

    int unsigned errors, cycles, checked, fails, moves;
    int unsigned send_idle, recv_idle;
    int unsigned hold_reqs, hold_done, hold_cnt;
    logic        accepted;
    logic [15:0] last_addr;

    // ---------------------------------------------------------------- model
    function automatic int size_class(int unsigned n);
        for (int k = 0; k < LargeClass; k++)
            if (n <= (GranuleBytes << k)) return k;
        return LargeClass;
    endfunction

    function automatic int slot_of(logic [15:0] a);
        logic [15:0] s;
        s = a - 16'(HeaderBytes);
        return int'(s[15:5]) % BlockSlots;
    endfunction

    // Carve or pop a block; returns 0 when the arena is exhausted.
    function automatic bit carve_block(int unsigned req, output logic [15:0] a);
        int unsigned n, cur, prev, steps, ci, start, pg, g;
        int k;
        n = ((req + HeaderBytes + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
        k = size_class(n);
        if (k < LargeClass) n = GranuleBytes << k;
        cur = heads[k];
        prev = 0;
        steps = 0;
        a = '0;
        if (k == LargeClass) begin
            // first fit, bounded so a looped list still terminates
            while (cur != 0) begin
                if (steps >= BlockSlots) begin
                    cur = 0;
                    break;
                end
                if (sizes[(cur - 1) % BlockSlots] >= n) break;
                prev = cur;
                cur = links[(cur - 1) % BlockSlots];
                steps++;
            end
        end
        if (cur != 0) begin
            ci = (cur - 1) % BlockSlots;
            if (prev == 0) heads[k] = links[ci];
            else links[(prev - 1) % BlockSlots] = links[ci];
            links[ci] = '0;
            a = 16'(ci * GranuleBytes + HeaderBytes);
            return 1'b1;
        end
        if (limit != 0 && cursor <= limit && limit - cursor >= n) begin
            start = cursor;
            cursor += n;
        end else begin
            pg = (n > MinPageBytes) ? n : MinPageBytes;
            if (limit > ArenaBytes || pg > ArenaBytes - limit) return 1'b0;
            start = limit;
            cursor = start + n;
            limit = start + pg;
        end
        g = (start / GranuleBytes) % BlockSlots;
        links[g] = '0;
        sizes[g] = 17'(n);
        stored[g] = 1'b1;
        a = 16'(start + HeaderBytes);
        return 1'b1;
    endfunction

    function automatic void push_block(logic [15:0] a);
        int g, k;
        if (a == 0) return;
        g = slot_of(a);
        k = size_class(sizes[g]);
        links[g] = heads[k];
        heads[k] = 12'(g + 1);
    endfunction

    function automatic void drop_live(logic [15:0] a);
        foreach (live_blocks[i])
            if (slot_of(16'(live_blocks[i])) == slot_of(a)) begin
                live_blocks.delete(i);
                return;
            end
    endfunction

    function automatic t_response predict_beat(t_request r);
        t_response res;
        logic [15:0] a;
        res = '0;
        case (r.op)
            OP_ALLOC: begin
                if (carve_block(r.req, a)) begin
                    res.addr = a;
                    live_blocks.push_back(a);
                end else res.status = 1'b1;
            end
            OP_FREE: begin
                push_block(r.addr);
                if (r.addr != 0) drop_live(r.addr);
            end
            OP_REALLOC: begin
                if (r.addr == 0) begin
                    if (carve_block(r.req, a)) begin
                        res.addr = a;
                        live_blocks.push_back(a);
                    end else res.status = 1'b1;
                end else if (sizes[slot_of(r.addr)] >= r.req + HeaderBytes) begin
                    res.addr = r.addr;           // still fits, keep in place
                end else if (carve_block(r.req, a)) begin
                    push_block(r.addr);
                    drop_live(r.addr);
                    live_blocks.push_back(a);
                    res.addr = a;
                    res.copy = 1'b1;
                end else res.status = 1'b1;     // old block stays allocated
            end
            default: begin
                // release wipes lists and pages; block stores keep their contents
                foreach (heads[i]) heads[i] = '0;
                cursor = 0;
                limit = 0;
                live_blocks.delete();
            end
        endcase
        if (res.status) fails++;
        if (res.copy) moves++;
        return res;
    endfunction

    // ---------------------------------------------------------------- clock, reset
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- driver
    initial begin
        i_valid = 1'b0;
        i_operation = '0;
        i_request_bytes = '0;
        i_address = '0;
        i_ready = 1'b0;
        accepted = 1'b0;
        foreach (heads[i]) heads[i] = '0;
        foreach (links[i]) begin
            links[i] = '0;
            sizes[i] = '0;
            stored[i] = 1'b0;
        end
        cursor = 0;
        limit = 0;
    end

    // Load a new beat once the previous one is gone; valid stays up until taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || accepted)) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                i_operation <= pending_beats[0].op;
                i_request_bytes <= pending_beats[0].req;
                i_address <= pending_beats[0].addr;
                i_valid <= 1'b1;
                void'(pending_beats.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Acceptance: predict the result of every beat the block takes.
    always @(posedge i_clk) begin
        t_request r;
        t_response e;
        accepted <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            r.op = t_op'(i_operation);
            r.req = i_request_bytes;
            r.addr = i_address;
            e = predict_beat(r);
            if (!e.status && e.addr != 0) last_addr = e.addr;
            expected_results.push_back(e);
        end
    end

    // ---------------------------------------------------------------- receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (hold_reqs != hold_done) begin
            hold_done <= hold_reqs;
            hold_cnt <= 400;               // long stall, input side must back up
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_response e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: addr %h", o_result_address);
                errors++;
            end else begin
                e = expected_results.pop_front();
                checked++;
                if (o_result_address !== e.addr) begin
                    $error("result_address expected %h got %h", e.addr, o_result_address);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_copy_needed !== e.copy) begin
                    $error("copy_needed expected %0d got %0d", e.copy, o_copy_needed);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic send(t_op op, int unsigned req, logic [15:0] addr);
        t_request r;
        r.op = op;
        r.req = 16'(req);
        r.addr = addr;
        pending_beats.push_back(r);
        wait (pending_beats.size() == 0);
    endtask

    task automatic drain();
        wait (pending_beats.size() == 0 && !i_valid && expected_results.size() == 0);
    endtask

    // Addresses for free / realloc: only slots that were sized at some point.
    function automatic logic [15:0] pick_addr();
        logic [15:0] a;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 20) begin
            a = 16'($urandom);
            if (stored[slot_of(a)]) return a;
        end
        if (live_blocks.size() == 0) return '0;
        a = 16'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
        if ($urandom_range(3) == 0) a = a + 16'($urandom_range(31));  // stray low bits
        return a;
    endfunction

    function automatic int unsigned pick_size();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55) return $urandom_range(200, 1);
        if (roll < 80) return $urandom_range(4000, 1);
        if (roll < 96) return $urandom_range(12000, 8000);   // around the large class
        return $urandom_range(65535, 1);
    endfunction

    initial begin
        int unsigned roll;
        logic [15:0] a, b;
        errors = 0;
        checked = 0;
        fails = 0;
        moves = 0;
        cycles = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_cnt = 0;
        send_idle = 0;
        recv_idle = 0;
        last_addr = '0;
        wait (i_rst_n);

        // directed: extremes, each operation, special cases
        send(OP_FREE, 1, '0);              // free of null
        send(OP_ALLOC, 1, '0);
        drain();
        a = last_addr;
        send(OP_ALLOC, 65535, '0);         // too big for the arena
        send(OP_ALLOC, 8177, '0);          // smallest large-class request
        drain();
        b = last_addr;
        send(OP_FREE, 1, b + 16'd7);       // odd address, low bits dropped
        send(OP_ALLOC, 8177, '0);          // first-fit walk hit
        send(OP_REALLOC, 1, a);            // fits, kept
        send(OP_REALLOC, 500, a);          // moves
        send(OP_REALLOC, 100, '0);         // realloc of null
        drain();
        send(OP_REALLOC, 65535, last_addr); // move fails, old block kept
        send(OP_FREE, 1, b);
        send(OP_ALLOC, 100, '0);
        send(OP_RELEASE, 1, '0);
        send(OP_ALLOC, 60000, '0);         // nearly fills the arena
        send(OP_ALLOC, 8000, '0);          // out of space
        send(OP_ALLOC, 32, '0);
        send(OP_RELEASE, 65535, 16'hffff);
        drain();

        // random phases: receiver idle heavy, then sender idle heavy, then none
        for (int unsigned i = 0; i < RandomBeats; i++) begin
            if (i == 0) begin send_idle = 23; recv_idle = 87; end
            if (i == 350) begin send_idle = 87; recv_idle = 23; end
            if (i == 700) begin send_idle = 0; recv_idle = 0; end
            if (i == 150 || i == 800) hold_reqs++;
            if (i == 500 || i == 900) drain();   // sender waits for every result
            roll = $urandom_range(99);
            if (roll < 42) send(OP_ALLOC, pick_size(), '0);
            else if (roll < 75) send(OP_FREE, pick_size(), pick_addr());
            else if (roll < 97) send(OP_REALLOC, pick_size(), pick_addr());
            else send(OP_RELEASE, pick_size(), 16'($urandom));
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("checked %0d results: %0d out-of-space, %0d moved reallocs",
                 checked, fails, moves);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
